// ----- design/gss_pkg.sv -----
// shared types, constants and register codes for the gear-shift sequencer
`default_nettype none

package gss_pkg;

   // design limits and fixed constants of the paddle tracking law
   localparam int MAX_GEAR     = 5;
   localparam int PADDLE_BASE  = 375;
   localparam int PADDLE_SPAN  = 120;
   localparam int CLUTCH_SCALE = 385;
   localparam int NEAR_BAND    = 5;
   localparam int HOLD_BAND    = 115;
   localparam int POS_W        = 10;
   localparam int GEAR_W       = 3;
   localparam int CSR_INDEX_W  = 3;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_UP_POSITION           = 3'd0,
      CSR_DOWN_POSITION         = 3'd1,
      CSR_REST_POSITION         = 3'd2,
      CSR_NEUTRAL_UP_POSITION   = 3'd3,
      CSR_NEUTRAL_DOWN_POSITION = 3'd4,
      CSR_CLUTCH_ENGAGE         = 3'd5,
      CSR_CLUTCH_RELEASE        = 3'd6,
      CSR_PADDLE_THRESHOLD      = 3'd7
   } csr_index_type;

   // reset values of the configuration registers
   localparam logic [POS_W-1:0] UP_POSITION_RST           = 10'd952;
   localparam logic [POS_W-1:0] DOWN_POSITION_RST         = 10'd69;
   localparam logic [POS_W-1:0] REST_POSITION_RST         = 10'd532;
   localparam logic [POS_W-1:0] NEUTRAL_UP_POSITION_RST   = 10'd740;
   localparam logic [POS_W-1:0] NEUTRAL_DOWN_POSITION_RST = 10'd230;
   localparam logic [POS_W-1:0] CLUTCH_ENGAGE_RST         = 10'd193;
   localparam logic [POS_W-1:0] CLUTCH_RELEASE_RST        = 10'd0;
   localparam logic [POS_W-1:0] PADDLE_THRESHOLD_RST      = 10'd375;

   // sequencer modes
   typedef enum logic [2:0] {
      MODE_IDLE     = 3'd0,
      MODE_UP       = 3'd1,
      MODE_DOWN     = 3'd2,
      MODE_CHECK    = 3'd3,
      MODE_NFIRST   = 3'd4,
      MODE_NSECOND  = 3'd5,
      MODE_NEUTRAL  = 3'd6,
      MODE_PADDLE   = 3'd7
   } mode_type;

   // configuration register set
   typedef struct packed {
      logic [POS_W-1:0] up_position;
      logic [POS_W-1:0] down_position;
      logic [POS_W-1:0] rest_position;
      logic [POS_W-1:0] neutral_up_position;
      logic [POS_W-1:0] neutral_down_position;
      logic [POS_W-1:0] clutch_engage_position;
      logic [POS_W-1:0] clutch_release_position;
      logic [POS_W-1:0] paddle_threshold;
   } cfg_type;

   // one sample tick
   typedef struct packed {
      logic             up_pressed;
      logic             down_pressed;
      logic             neutral_pressed;
      logic [POS_W-1:0] shift_position;
      logic [POS_W-1:0] clutch_position;
      logic [POS_W-1:0] paddle_position;
   } req_type;

   // one result per tick
   typedef struct packed {
      logic              shift_drive;
      logic              shift_toward_up;
      logic              clutch_drive;
      logic              clutch_toward_release;
      logic              spark_cut;
      logic [GEAR_W-1:0] gear;
      logic              neutral;
      logic              busy_res;
   } rsp_type;

endpackage

`default_nettype wire

// ----- design/gss_core.sv -----
// sequencer state registers and the per-tick next-state and drive logic
`default_nettype none

module gss_core #(
   parameter int MAX_GEAR = gss_pkg::MAX_GEAR
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire gss_pkg::cfg_type cfg,
   input  wire gss_pkg::req_type req,
   output gss_pkg::rsp_type      rsp
);

   localparam logic [gss_pkg::GEAR_W-1:0] GearMax = gss_pkg::GEAR_W'(MAX_GEAR);
   localparam logic [gss_pkg::GEAR_W-1:0] GearOne = gss_pkg::GEAR_W'(1);
   localparam logic [gss_pkg::GEAR_W-1:0] GearTwo = gss_pkg::GEAR_W'(2);

   gss_pkg::mode_type               mode_ff, mode_in;
   logic [2:0]                      phase_ff, phase_in;
   logic [gss_pkg::GEAR_W-1:0]      gear_ff, gear_in;
   logic                            neutral_ff, neutral_in;
   logic                            left_neutral_ff, left_neutral_in;
   logic                            hold_ff, hold_in;

   // drive outputs of this tick
   logic sd, su, cd, cr, ic;

   // phase as seen by the stroke sequences (a released button enters phase one)
   logic [2:0] eph;
   assign eph = (phase_ff == 3'd0) ? 3'd1 : phase_ff;

   // plain sequence: stroke up to a threshold, then back down to rest
   logic [gss_pkg::POS_W-1:0] pl_stroke;
   logic                      pl_ign;
   logic                      pl_sd, pl_su, pl_ic, pl_done;
   logic [2:0]                pl_phase;

   assign pl_stroke = (mode_ff == gss_pkg::MODE_NFIRST || neutral_ff) ?
                      cfg.neutral_up_position : cfg.up_position;
   assign pl_ign    = (mode_ff == gss_pkg::MODE_UP) && !neutral_ff;

   always_comb begin
      pl_sd    = 1'b0;
      pl_su    = 1'b0;
      pl_ic    = 1'b0;
      pl_done  = 1'b0;
      pl_phase = 3'd2;
      if (eph == 3'd1 && req.shift_position < pl_stroke) begin
         pl_sd    = 1'b1;
         pl_su    = 1'b1;
         pl_ic    = pl_ign;
         pl_phase = 3'd1;
      end else if (req.shift_position > cfg.rest_position) begin
         pl_sd = 1'b1;
      end else begin
         pl_done = 1'b1;
      end
   end

   // clutched sequence: clutch out, stroke down, back up to rest, clutch in
   logic [gss_pkg::POS_W-1:0] cl_stroke;
   logic                      cl_sd, cl_su, cl_cd, cl_cr, cl_done;
   logic [2:0]                cl_phase;

   assign cl_stroke = (mode_ff == gss_pkg::MODE_DOWN) ?
                      cfg.down_position : cfg.neutral_down_position;

   always_comb begin
      cl_sd    = 1'b0;
      cl_su    = 1'b0;
      cl_cd    = 1'b0;
      cl_cr    = 1'b0;
      cl_done  = 1'b0;
      cl_phase = 3'd4;
      if (eph == 3'd1 && req.clutch_position < cfg.clutch_engage_position) begin
         cl_cd    = 1'b1;
         cl_phase = 3'd1;
      end else if (eph <= 3'd2 && req.shift_position > cl_stroke) begin
         cl_sd    = 1'b1;
         cl_phase = 3'd2;
      end else if (eph <= 3'd3 && req.shift_position < cfg.rest_position) begin
         cl_sd    = 1'b1;
         cl_su    = 1'b1;
         cl_phase = 3'd3;
      end else if (req.clutch_position > cfg.clutch_release_position) begin
         cl_cd = 1'b1;
         cl_cr = 1'b1;
      end else begin
         cl_done = 1'b1;
      end
   end

   // paddle tracking: (paddle - base) * scale against clutch * span, exact
   logic signed [19:0] pd_ext, cl_ext, target, current, diff;
   logic [19:0]        mag;
   logic               in_hold, in_near;

   assign pd_ext  = 20'($signed({1'b0, req.paddle_position}));
   assign cl_ext  = 20'($signed({1'b0, req.clutch_position}));
   assign target  = (pd_ext - 20'(gss_pkg::PADDLE_BASE)) * 20'(gss_pkg::CLUTCH_SCALE);
   assign current = cl_ext * 20'(gss_pkg::PADDLE_SPAN);
   assign diff    = target - current;
   assign mag     = diff[19] ? 20'(-diff) : 20'(diff);
   assign in_hold = mag < 20'(gss_pkg::HOLD_BAND * gss_pkg::PADDLE_SPAN);
   assign in_near = mag < 20'(gss_pkg::NEAR_BAND * gss_pkg::PADDLE_SPAN);

   // mode sequencing and drive selection
   always_comb begin
      mode_in         = mode_ff;
      phase_in        = phase_ff;
      gear_in         = gear_ff;
      neutral_in      = neutral_ff;
      left_neutral_in = left_neutral_ff;
      hold_in         = hold_ff;
      sd = 1'b0;
      su = 1'b0;
      cd = 1'b0;
      cr = 1'b0;
      ic = 1'b0;
      unique case (mode_ff)
         gss_pkg::MODE_IDLE: begin
            priority if (req.up_pressed && gear_ff < GearMax) begin
               mode_in  = gss_pkg::MODE_UP;
               phase_in = 3'd0;
            end else if (req.down_pressed) begin
               mode_in  = gss_pkg::MODE_DOWN;
               phase_in = 3'd0;
            end else if (req.neutral_pressed && !left_neutral_ff) begin
               mode_in  = gss_pkg::MODE_CHECK;
               phase_in = 3'd0;
            end else if (req.paddle_position > cfg.paddle_threshold) begin
               mode_in  = gss_pkg::MODE_PADDLE;
               phase_in = 3'd0;
               hold_in  = 1'b0;
            end else begin
               mode_in = gss_pkg::MODE_IDLE;
            end
            left_neutral_in = 1'b0;
         end
         gss_pkg::MODE_UP: begin
            if (!(phase_ff == 3'd0 && req.up_pressed)) begin
               sd       = pl_sd;
               su       = pl_su;
               ic       = pl_ic;
               phase_in = pl_phase;
               if (pl_done) begin
                  neutral_in = 1'b0;
                  if (gear_ff < GearMax) gear_in = gear_ff + GearOne;
                  mode_in  = gss_pkg::MODE_IDLE;
                  phase_in = 3'd0;
                  hold_in  = 1'b0;
               end
            end
         end
         gss_pkg::MODE_DOWN: begin
            if (!(phase_ff == 3'd0 && req.down_pressed)) begin
               if (phase_ff == 3'd0) neutral_in = 1'b0;
               sd       = cl_sd;
               su       = cl_su;
               cd       = cl_cd;
               cr       = cl_cr;
               phase_in = cl_phase;
               if (cl_done) begin
                  if (gear_ff > GearOne) gear_in = gear_ff - GearOne;
                  mode_in  = gss_pkg::MODE_IDLE;
                  phase_in = 3'd0;
                  hold_in  = 1'b0;
               end
            end
         end
         gss_pkg::MODE_CHECK: begin
            if (!req.neutral_pressed) begin
               phase_in = 3'd1;
               priority if (gear_ff == GearOne) begin
                  mode_in = gss_pkg::MODE_NFIRST;
               end else if (gear_ff == GearTwo) begin
                  mode_in = gss_pkg::MODE_NSECOND;
               end else begin
                  mode_in  = gss_pkg::MODE_IDLE;
                  phase_in = 3'd0;
                  hold_in  = 1'b0;
               end
            end
         end
         gss_pkg::MODE_NFIRST: begin
            if (!neutral_ff) begin
               sd       = pl_sd;
               su       = pl_su;
               ic       = pl_ic;
               phase_in = pl_phase;
            end
            if (neutral_ff || pl_done) begin
               neutral_in = 1'b1;
               mode_in    = gss_pkg::MODE_NEUTRAL;
               phase_in   = 3'd0;
            end
         end
         gss_pkg::MODE_NSECOND: begin
            if (!neutral_ff) begin
               sd       = cl_sd;
               su       = cl_su;
               cd       = cl_cd;
               cr       = cl_cr;
               phase_in = cl_phase;
            end
            if (neutral_ff || cl_done) begin
               neutral_in = 1'b1;
               if (gear_ff > GearOne) gear_in = gear_ff - GearOne;
               mode_in  = gss_pkg::MODE_NEUTRAL;
               phase_in = 3'd0;
            end
         end
         gss_pkg::MODE_NEUTRAL: begin
            neutral_in      = 1'b1;
            left_neutral_in = 1'b1;
            mode_in         = gss_pkg::MODE_IDLE;
            phase_in        = 3'd0;
            hold_in         = 1'b0;
         end
         gss_pkg::MODE_PADDLE: begin
            if (!(hold_ff && in_hold)) begin
               hold_in = 1'b0;
               priority if (req.paddle_position < cfg.paddle_threshold || diff == 20'sd0) begin
                  mode_in  = gss_pkg::MODE_IDLE;
                  phase_in = 3'd0;
               end else if (in_near) begin
                  hold_in = 1'b1;
               end else begin
                  cd = 1'b1;
                  cr = diff[19];
               end
            end
         end
         default: begin
            mode_in  = gss_pkg::MODE_IDLE;
            phase_in = 3'd0;
            hold_in  = 1'b0;
         end
      endcase
   end

   // result of this tick
   always_comb begin
      rsp.shift_drive           = sd;
      rsp.shift_toward_up       = su;
      rsp.clutch_drive          = cd;
      rsp.clutch_toward_release = cr;
      rsp.spark_cut             = ic;
      rsp.gear                  = gear_in;
      rsp.neutral               = neutral_in;
      rsp.busy_res              = (mode_in != gss_pkg::MODE_IDLE);
   end

   // state registers, updated once per accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= gss_pkg::MODE_IDLE;
         phase_ff        <= 3'd0;
         gear_ff         <= GearOne;
         neutral_ff      <= 1'b0;
         left_neutral_ff <= 1'b0;
         hold_ff         <= 1'b0;
      end else if (advance) begin
         mode_ff         <= mode_in;
         phase_ff        <= phase_in;
         gear_ff         <= gear_in;
         neutral_ff      <= neutral_in;
         left_neutral_ff <= left_neutral_in;
         hold_ff         <= hold_in;
      end
   end

`ifndef SYNTHESIS
   // gear stays within its legal range
   a_gear_range: assert property (@(posedge clock) disable iff (reset)
      gear_ff >= GearOne && gear_ff <= GearMax)
      else $error("gear out of range");

   // one item moves the gear by at most one step
   a_gear_step: assert property (@(posedge clock) disable iff (reset)
      advance |=> (gear_ff == $past(gear_ff) ||
                   gear_ff == $past(gear_ff) + GearOne ||
                   gear_ff == $past(gear_ff) - GearOne))
      else $error("gear moved by more than one");

   // state holds while no item is taken
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(mode_ff) && $stable(gear_ff) && $stable(phase_ff)))
      else $error("state changed without an item");

   // ignition cut only during an upward shift stroke
   a_ign_cut: assert property (@(posedge clock) disable iff (reset)
      ic |-> (sd && su && mode_ff == gss_pkg::MODE_UP))
      else $error("ignition cut outside upshift stroke");

   // shift and clutch motors are never driven together
   a_one_motor: assert property (@(posedge clock) disable iff (reset)
      !(sd && cd))
      else $error("both motors driven");
`endif

endmodule

`default_nettype wire

// ----- design/gear_shift_sequencer.sv -----
// top level of the gear-shift sequencer: handshakes, registers and core
`default_nettype none

// Gear-shift sequencer. Each item is one sample tick (three button levels and
// three 10-bit position samples) and yields exactly one result item with the
// motor drives, ignition cut, gear, neutral and busy flags for that tick.
// An item is taken into an input register, evaluated by the sequencer logic
// while it is held there and written to a result register, which raises
// rsp_valid; the result waits there until rsp_ready takes it. One item is
// accepted every cycle while the result side keeps up; the rate is set by
// the single state update per item in the core. Configuration writes are
// always taken (csr_ready is high) and must be issued only while the block
// is idle.
module gear_shift_sequencer #(
   parameter int MAX_GEAR = gss_pkg::MAX_GEAR
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire gss_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output gss_pkg::rsp_type                       rsp_data,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [gss_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [gss_pkg::POS_W-1:0]         csr_data
);

   gss_pkg::cfg_type cfg_ff;
   gss_pkg::req_type req_ff;
   gss_pkg::rsp_type rsp_ff, rsp_in;
   logic             in_valid_ff;
   logic             out_valid_ff;
   logic             advance;

   // the core fires when an item is held and the result slot is free
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = rsp_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.up_position             <= gss_pkg::UP_POSITION_RST;
         cfg_ff.down_position           <= gss_pkg::DOWN_POSITION_RST;
         cfg_ff.rest_position           <= gss_pkg::REST_POSITION_RST;
         cfg_ff.neutral_up_position     <= gss_pkg::NEUTRAL_UP_POSITION_RST;
         cfg_ff.neutral_down_position   <= gss_pkg::NEUTRAL_DOWN_POSITION_RST;
         cfg_ff.clutch_engage_position  <= gss_pkg::CLUTCH_ENGAGE_RST;
         cfg_ff.clutch_release_position <= gss_pkg::CLUTCH_RELEASE_RST;
         cfg_ff.paddle_threshold        <= gss_pkg::PADDLE_THRESHOLD_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (gss_pkg::csr_index_type'(csr_index))
            gss_pkg::CSR_UP_POSITION:           cfg_ff.up_position <= csr_data;
            gss_pkg::CSR_DOWN_POSITION:         cfg_ff.down_position <= csr_data;
            gss_pkg::CSR_REST_POSITION:         cfg_ff.rest_position <= csr_data;
            gss_pkg::CSR_NEUTRAL_UP_POSITION:   cfg_ff.neutral_up_position <= csr_data;
            gss_pkg::CSR_NEUTRAL_DOWN_POSITION: cfg_ff.neutral_down_position <= csr_data;
            gss_pkg::CSR_CLUTCH_ENGAGE:         cfg_ff.clutch_engage_position <= csr_data;
            gss_pkg::CSR_CLUTCH_RELEASE:        cfg_ff.clutch_release_position <= csr_data;
            gss_pkg::CSR_PADDLE_THRESHOLD:      cfg_ff.paddle_threshold <= csr_data;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
   end

   // sequencer logic and state
   gss_core #(
      .MAX_GEAR (MAX_GEAR)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .cfg     (cfg_ff),
      .req     (req_ff),
      .rsp     (rsp_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire
